// File: rtl/cmd_pkg.sv
// ----------------------------------------------------------------------------
// cmd_pkg
// Shared types, register indexes and element-type codes for the code minimum
// distance block.
// ----------------------------------------------------------------------------
package cmd_pkg;

    localparam int SYM_W    = 32;
    localparam int DATA_W   = 9;
    localparam int INDEX_W  = 2;
    localparam int DIST_W   = 6;
    localparam int DIST_MAX = 63;

    // configuration register indexes
    localparam logic [INDEX_W-1:0] CFG_CODE_LENGTH    = 2'd0;
    localparam logic [INDEX_W-1:0] CFG_CODEWORD_COUNT = 2'd1;
    localparam logic [INDEX_W-1:0] CFG_LINEAR_MODE    = 2'd2;
    localparam logic [INDEX_W-1:0] CFG_ELEMENT_TYPE   = 2'd3;

    // element type codes
    localparam logic [2:0] ET_U8  = 3'd0;
    localparam logic [2:0] ET_U16 = 3'd1;
    localparam logic [2:0] ET_U32 = 3'd2;
    localparam logic [2:0] ET_S32 = 3'd3;

    typedef enum logic [1:0] {
        S_LOAD,
        S_BUSY,
        S_RESULT
    } t_state;

    // tag that travels with each pair of symbols read from the store
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic final_sym;
    } t_tag;

    // bits of a symbol that take part in a compare; zero counts nothing
    function automatic logic [SYM_W-1:0] f_type_mask(input logic [2:0] etype);
        logic [SYM_W-1:0] mask;
        case (etype) inside
            ET_U8:          mask = 32'h0000_00FF;
            ET_U16:         mask = 32'h0000_FFFF;
            ET_U32, ET_S32: mask = 32'hFFFF_FFFF;
            default:        mask = '0;
        endcase
        return mask;
    endfunction

endpackage

// File: rtl/cmd_ram.sv
// ----------------------------------------------------------------------------
// cmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/cmd_seq.sv
// ----------------------------------------------------------------------------
// cmd_seq
// Read sequencer: walks every codeword (weight mode) or every pair of
// codewords (distance mode) one symbol position per cycle.
// ----------------------------------------------------------------------------
module cmd_seq #(
    parameter int MAX_LENGTH = 32,
    parameter int MAX_WORDS  = 256
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_start,
    input  logic [$clog2(MAX_LENGTH+1)-1:0]                 i_len,
    input  logic [$clog2(MAX_WORDS+1)-1:0]                  i_cnt,
    input  logic                                            i_linear,
    output logic [$clog2(MAX_LENGTH*MAX_WORDS)-1:0]         o_addr_a,
    output logic [$clog2(MAX_LENGTH*MAX_WORDS)-1:0]         o_addr_b,
    output cmd_pkg::t_tag                                   o_tag
);
    import cmd_pkg::*;

    localparam int LW = $clog2(MAX_LENGTH + 1);
    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam int AW = $clog2(MAX_LENGTH * MAX_WORDS);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_a, n_a;
    logic [CW-1:0] r_b, n_b;
    logic [LW-1:0] r_r, n_r;
    logic [AW-1:0] r_addr_a, n_addr_a;
    logic [AW-1:0] r_addr_b, n_addr_b;
    logic [AW-1:0] r_base_a, n_base_a;
    logic [LW-1:0] r_len;
    logic [CW-1:0] r_cnt;
    logic          r_lin;
    t_tag          r_tag, n_tag;

    logic          w_last;
    logic          w_final;
    logic [AW-1:0] w_next_a;

    // position flags of the symbol issued this cycle
    always_comb begin
        w_last   = (r_r == r_len - LW'(1));
        w_next_a = r_addr_a + AW'(1);
        if (r_lin) begin
            w_final = w_last && (r_a == r_cnt - CW'(1));
        end else begin
            w_final = w_last && (r_b == r_cnt - CW'(1)) && (r_a + CW'(1) == r_b);
        end
    end

    // counter and address advance
    always_comb begin
        n_busy   = r_busy;
        n_a      = r_a;
        n_b      = r_b;
        n_r      = r_r;
        n_addr_a = r_addr_a;
        n_addr_b = r_addr_b;
        n_base_a = r_base_a;
        n_tag.valid     = r_busy;
        n_tag.first     = (r_r == '0);
        n_tag.last      = w_last;
        n_tag.final_sym = w_final;
        if (i_start) begin
            n_busy   = 1'b1;
            n_a      = '0;
            n_b      = CW'(1);
            n_r      = '0;
            n_addr_a = '0;
            n_base_a = '0;
            n_addr_b = AW'(i_len);
        end else if (r_busy) begin
            if (!w_last) begin
                n_r      = r_r + LW'(1);
                n_addr_a = w_next_a;
                n_addr_b = r_addr_b + AW'(1);
            end else begin
                n_r = '0;
                if (w_final) begin
                    n_busy = 1'b0;
                end
                if (r_lin) begin
                    n_a      = r_a + CW'(1);
                    n_addr_a = w_next_a;
                end else if (r_b != r_cnt - CW'(1)) begin
                    n_b      = r_b + CW'(1);
                    n_addr_b = r_addr_b + AW'(1);
                    n_addr_a = r_base_a;
                end else begin
                    n_a      = r_a + CW'(1);
                    n_b      = r_a + CW'(2);
                    n_base_a = w_next_a;
                    n_addr_a = w_next_a;
                    n_addr_b = w_next_a + AW'(r_len);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_tag  <= '0;
        end else begin
            r_busy <= n_busy;
            r_tag  <= n_tag;
        end
    end

    // counters, addresses and latched geometry
    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_r      <= n_r;
        r_addr_a <= n_addr_a;
        r_addr_b <= n_addr_b;
        r_base_a <= n_base_a;
        if (i_start) begin
            r_len <= i_len;
            r_cnt <= i_cnt;
            r_lin <= i_linear;
        end
    end

    assign o_addr_a = r_addr_a;
    assign o_addr_b = r_addr_b;
    assign o_tag    = r_tag;

endmodule

// File: rtl/cmd_acc.sv
// ----------------------------------------------------------------------------
// cmd_acc
// Distance accumulator: counts differing (or nonzero) symbols per codeword or
// pair and keeps the smallest candidate seen.
// ----------------------------------------------------------------------------
module cmd_acc #(
    parameter int MAX_LENGTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  cmd_pkg::t_tag                       i_tag,
    input  logic [cmd_pkg::SYM_W-1:0]           i_sym_a,
    input  logic [cmd_pkg::SYM_W-1:0]           i_sym_b,
    input  logic                                i_linear,
    input  logic [2:0]                          i_element_type,
    output logic [$clog2(MAX_LENGTH+1)-1:0]     o_best,
    output logic                                o_found,
    output logic                                o_done
);
    import cmd_pkg::*;

    localparam int LW = $clog2(MAX_LENGTH + 1);

    logic [SYM_W-1:0] w_mask;
    logic             w_neq;
    logic [LW-1:0]    w_sum;
    logic             w_take;

    logic [LW-1:0]    r_acc;
    logic [LW-1:0]    r_best;
    logic             r_found;
    logic             r_done;

    // per-position compare and running count
    always_comb begin
        w_mask = f_type_mask(i_element_type);
        if (i_linear) begin
            w_neq = ((i_sym_a & w_mask) != '0);
        end else begin
            w_neq = (((i_sym_a ^ i_sym_b) & w_mask) != '0);
        end
        w_sum  = (i_tag.first ? '0 : r_acc) + LW'(w_neq);
        w_take = i_tag.valid && i_tag.last && !(i_linear && (w_sum == '0))
                 && (!r_found || (w_sum < r_best));
    end

    // found flag and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_tag.valid && i_tag.final_sym;
            if (w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    // running count and best candidate
    always_ff @(posedge i_clk) begin
        if (i_tag.valid) begin
            r_acc <= w_sum;
        end
        if (w_take) begin
            r_best <= w_sum;
        end
    end

    assign o_best  = r_best;
    assign o_found = r_found;
    assign o_done  = r_done;

endmodule

// File: rtl/code_minimum_distance.sv
// ----------------------------------------------------------------------------
// code_minimum_distance
// Minimum distance of a block code loaded one symbol per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_symbol) takes one symbol per
//   cycle, codeword 0 first, symbol 0 first within each codeword. The load
//   ends once code_length * codeword_count symbols are in.
//   Then the block computes and offers one result transaction on the output
//   channel (o_out_valid / i_out_ready, o_min_distance, o_none_found).
//   Compute: distance mode walks every pair of codewords and weight mode
//   every codeword, one symbol position per cycle read from two mirrored
//   copies of the symbol store.
//   A distance-mode load of one codeword yields its result on the next cycle.
//   o_in_ready is low from the end of a load until the result is taken; a
//   stall on the output holds the result and the block.
//   Configuration (i_cfg_we, i_cfg_index, i_cfg_data) is to be written only
//   while idle, a rule on the user that the block itself does not enforce.
//   Reset returns the registers to length 1, count 1, distance mode, 8-bit
//   elements, and clears the load position. The store itself is not cleared.
// ----------------------------------------------------------------------------
module code_minimum_distance #(
    parameter int MAX_LENGTH = 32,
    parameter int MAX_WORDS  = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cmd_pkg::INDEX_W-1:0]    i_cfg_index,
    input  logic [cmd_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [cmd_pkg::SYM_W-1:0]      i_symbol,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [cmd_pkg::DIST_W-1:0]     o_min_distance,
    output logic                           o_none_found
);
    import cmd_pkg::*;

    localparam int DEPTH = MAX_LENGTH * MAX_WORDS;
    localparam int LW    = $clog2(MAX_LENGTH + 1);
    localparam int CW    = $clog2(MAX_WORDS + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);

    logic [5:0]    r_code_length;
    logic [8:0]    r_codeword_count;
    logic          r_linear_mode;
    logic [2:0]    r_element_type;
    logic [AW-1:0] r_pos;
    t_state        r_state, n_state;

    logic [LW-1:0] w_len;
    logic [CW-1:0] w_cnt;
    logic [TW-1:0] w_total;
    logic          w_accept;
    logic          w_load_end;
    logic          w_no_pair;
    logic          w_start;
    logic          w_clear;

    logic [AW-1:0]    w_addr_a;
    logic [AW-1:0]    w_addr_b;
    t_tag             w_tag;
    logic [SYM_W-1:0] w_sym_a;
    logic [SYM_W-1:0] w_sym_b;
    logic [LW-1:0]    w_best;
    logic             w_found;
    logic             w_done;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_length    <= 6'd1;
            r_codeword_count <= 9'd1;
            r_linear_mode    <= 1'b0;
            r_element_type   <= ET_U8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CODE_LENGTH:    r_code_length    <= i_cfg_data[5:0];
                CFG_CODEWORD_COUNT: r_codeword_count <= i_cfg_data;
                CFG_LINEAR_MODE:    r_linear_mode    <= i_cfg_data[0];
                CFG_ELEMENT_TYPE:   r_element_type   <= i_cfg_data[2:0];
                default:            ;
            endcase
        end
    end

    // effective geometry and end-of-load detect
    always_comb begin
        if (r_code_length == '0) begin
            w_len = LW'(1);
        end else if (32'(r_code_length) > 32'(MAX_LENGTH)) begin
            w_len = LW'(MAX_LENGTH);
        end else begin
            w_len = LW'(r_code_length);
        end
        if (r_codeword_count == '0) begin
            w_cnt = CW'(1);
        end else if (32'(r_codeword_count) > 32'(MAX_WORDS)) begin
            w_cnt = CW'(MAX_WORDS);
        end else begin
            w_cnt = CW'(r_codeword_count);
        end
        w_total    = TW'(w_len) * TW'(w_cnt);
        w_accept   = i_in_valid && o_in_ready;
        w_load_end = w_accept && ((TW'(r_pos) + TW'(1)) >= w_total);
        w_no_pair  = !r_linear_mode && (w_cnt == CW'(1));
        w_start    = w_load_end && !w_no_pair;
        w_clear    = w_load_end;
    end

    // load position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_accept) begin
            r_pos <= w_load_end ? '0 : r_pos + AW'(1);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake outputs
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (w_load_end) begin
                    n_state = w_no_pair ? S_RESULT : S_BUSY;
                end
            end
            S_BUSY: begin
                if (w_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // result fields, saturated at the field range
    always_comb begin
        o_none_found = !w_found;
        if (!w_found) begin
            o_min_distance = '0;
        end else if (32'(w_best) > 32'(DIST_MAX)) begin
            o_min_distance = DIST_W'(DIST_MAX);
        end else begin
            o_min_distance = DIST_W'(w_best);
        end
    end

    // two mirrored copies of the symbol store give two reads per cycle
    cmd_ram #(
        .WIDTH (SYM_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_pos),
        .i_wdata (i_symbol),
        .i_raddr (w_addr_a),
        .o_rdata (w_sym_a)
    );

    cmd_ram #(
        .WIDTH (SYM_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_pos),
        .i_wdata (i_symbol),
        .i_raddr (w_addr_b),
        .o_rdata (w_sym_b)
    );

    cmd_seq #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_WORDS  (MAX_WORDS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_len    (w_len),
        .i_cnt    (w_cnt),
        .i_linear (r_linear_mode),
        .o_addr_a (w_addr_a),
        .o_addr_b (w_addr_b),
        .o_tag    (w_tag)
    );

    cmd_acc #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (w_clear),
        .i_tag          (w_tag),
        .i_sym_a        (w_sym_a),
        .i_sym_b        (w_sym_b),
        .i_linear       (r_linear_mode),
        .i_element_type (r_element_type),
        .o_best         (w_best),
        .o_found        (w_found),
        .o_done         (w_done)
    );

`ifndef ASSERT_OFF
    // never loading while a result is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    // a result appears only after a compute run or a single-word load
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state == S_BUSY) || $past(w_load_end)))
        else $error("result without compute");

    // none found always reports a zero distance
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_none_found) |-> (o_min_distance == '0))
        else $error("none found with nonzero distance");

    // after the result transaction the block loads again
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready)
        else $error("not ready after result");
`endif

endmodule

// File: sim/tb_code_minimum_distance.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_code_minimum_distance
// Self-checking bench for the code minimum distance block. Codeword symbols
// are streamed in with random gaps and the result channel is stalled at
// random. A behavioral predictor mirrors the configuration and the symbol
// store, works out the minimum distance or weight at the end of every load,
// and each result transaction is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_code_minimum_distance;

    import cmd_pkg::*;

    localparam int          MAX_LEN        = 32;
    localparam int          MAX_CW         = 256;
    localparam int          STORE_DEPTH    = MAX_LEN * MAX_CW;
    localparam int          BUF_DEPTH      = 8192;
    localparam int          RANDOM_SYMBOLS = 960;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          HOLD_CYCLES    = 400;
    localparam longint      TIMEOUT_NS     = 10_000_000;
    localparam logic [2:0]  ET_UNKNOWN_LO  = 3'd4;
    localparam logic [2:0]  ET_UNKNOWN_HI  = 3'd7;

    typedef struct packed {
        logic [DIST_W-1:0] min_distance;
        logic              none_found;
    } t_distance_result;

    typedef enum int {
        FILL_RANDOM,
        FILL_ALPHABET,
        FILL_NEAR,
        FILL_SPARSE
    } t_fill_style;

    // dut signals
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [INDEX_W-1:0]   i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [SYM_W-1:0]     i_symbol    = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [DIST_W-1:0]    o_min_distance;
    logic                 o_none_found;

    // predictor state
    logic [5:0]           cur_len    = 6'd1;
    logic [8:0]           cur_cnt    = 9'd1;
    logic                 cur_linear = 1'b0;
    logic [2:0]           cur_etype  = ET_U8;
    logic [SYM_W-1:0]     sym_store [0:STORE_DEPTH-1];
    int unsigned          load_pos   = 0;
    t_distance_result     expected_q [$];

    // stimulus state
    logic [SYM_W-1:0]     cw_buf [0:BUF_DEPTH-1];
    bit                   sender_idle_en   = 1'b1;
    bit                   receiver_idle_en = 1'b1;
    int unsigned          rx_hold_cycles   = 0;
    int unsigned          mismatches       = 0;

    code_minimum_distance uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_symbol       (i_symbol),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_min_distance (o_min_distance),
        .o_none_found   (o_none_found)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic int unsigned clamp_length(input logic [5:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_LEN) return MAX_LEN;
        return 32'(raw);
    endfunction

    function automatic int unsigned clamp_count(input logic [8:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_CW) return MAX_CW;
        return 32'(raw);
    endfunction

    // least pairwise distance, or least nonzero weight in linear mode
    function automatic t_distance_result predict_min_distance(input int unsigned len,
                                                              input int unsigned cnt);
        t_distance_result res;
        logic [SYM_W-1:0] mask;
        int unsigned      best;
        int unsigned      d;
        bit               found;
        case (cur_etype)
            ET_U8:          mask = 32'h0000_00FF;
            ET_U16:         mask = 32'h0000_FFFF;
            ET_U32, ET_S32: mask = 32'hFFFF_FFFF;
            default:        mask = '0;
        endcase
        found = 1'b0;
        best  = 0;
        if (cur_linear) begin
            for (int unsigned a = 0; a < cnt; a++) begin
                d = 0;
                for (int unsigned r = 0; r < len; r++)
                    if ((sym_store[a*len + r] & mask) != 0) d++;
                if (d != 0) begin
                    if (!found || d < best) best = d;
                    found = 1'b1;
                end
            end
        end else begin
            for (int unsigned a = 0; a < cnt; a++) begin
                for (int unsigned b = a + 1; b < cnt; b++) begin
                    d = 0;
                    for (int unsigned r = 0; r < len; r++)
                        if (((sym_store[a*len + r] ^ sym_store[b*len + r]) & mask) != 0) d++;
                    if (!found || d < best) best = d;
                    found = 1'b1;
                end
            end
        end
        if (found) begin
            res.min_distance = (best > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(best);
            res.none_found   = 1'b0;
        end else begin
            res.min_distance = '0;
            res.none_found   = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 10) $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // track config writes, check result transactions, predict on input transactions
    always @(posedge i_clk) begin : monitor_blk
        t_distance_result want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CODE_LENGTH:    cur_len    = i_cfg_data[5:0];
                    CFG_CODEWORD_COUNT: cur_cnt    = i_cfg_data[8:0];
                    CFG_LINEAR_MODE:    cur_linear = i_cfg_data[0];
                    CFG_ELEMENT_TYPE:   cur_etype  = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with none expected: min_distance %0d none_found %0d",
                        o_min_distance, o_none_found));
                end else begin
                    want = expected_q.pop_front();
                    if (o_min_distance !== want.min_distance)
                        report_mismatch($sformatf("min_distance expected %0d got %0d",
                                                  want.min_distance, o_min_distance));
                    if (o_none_found !== want.none_found)
                        report_mismatch($sformatf("none_found expected %0d got %0d",
                                                  want.none_found, o_none_found));
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (load_pos < STORE_DEPTH) sym_store[load_pos] = i_symbol;
                load_pos++;
                if (load_pos >= clamp_length(cur_len) * clamp_count(cur_cnt)) begin
                    load_pos = 0;
                    expected_q.push_back(predict_min_distance(clamp_length(cur_len),
                                                              clamp_count(cur_cnt)));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: random stall per transaction, or a requested long hold
    // ------------------------------------------------------------------------
    initial begin : receiver_blk
        int unsigned stall;
        forever begin
            if (rx_hold_cycles != 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = receiver_idle_en ? $urandom_range(0, 15) : 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one symbol transaction; valid stays high after acceptance
    task automatic send_symbol(input logic [SYM_W-1:0] sym);
        int unsigned gap;
        gap = sender_idle_en ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_symbol   <= sym;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_load(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) send_symbol(cw_buf[k]);
        i_in_valid <= 1'b0;
    endtask

    // sender pause until every expected result is in, then let the block settle
    task automatic wait_for_results();
        // wait on the clock first so the monitor has logged the last input transaction
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [DATA_W-1:0] len_d, input logic [DATA_W-1:0] cnt_d,
                              input logic [DATA_W-1:0] lin_d, input logic [DATA_W-1:0] et_d);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CODE_LENGTH;
        i_cfg_data  <= len_d;
        @(posedge i_clk);
        i_cfg_index <= CFG_CODEWORD_COUNT;
        i_cfg_data  <= cnt_d;
        @(posedge i_clk);
        i_cfg_index <= CFG_LINEAR_MODE;
        i_cfg_data  <= lin_d;
        @(posedge i_clk);
        i_cfg_index <= CFG_ELEMENT_TYPE;
        i_cfg_data  <= et_d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // fill cw_buf from base with one load of random codewords
    function automatic void fill_random_load(input int unsigned base, input int unsigned len,
                                             input int unsigned cnt);
        logic [SYM_W-1:0] alpha [0:5];
        logic [SYM_W-1:0] first_word [0:MAX_LEN-1];
        logic [SYM_W-1:0] s;
        t_fill_style      style;
        int unsigned      k;
        alpha = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0100,
                  32'h0001_0000, 32'h8000_0000, 32'hFFFF_FFFF};
        style = t_fill_style'($urandom_range(0, 3));
        for (int unsigned w = 0; w < cnt; w++) begin
            for (int unsigned p = 0; p < len; p++) begin
                k = $urandom_range(0, 7);
                s = (k < 6) ? alpha[k] : $urandom;
                case (style)
                    FILL_RANDOM:   s = $urandom;
                    FILL_ALPHABET: ;
                    // mostly copies of the first codeword, so distances stay low
                    FILL_NEAR:     if (w != 0 && $urandom_range(0, 3) != 0) s = first_word[p];
                    default:       if ($urandom_range(0, 3) != 0) s = '0;
                endcase
                if (w == 0) first_word[p] = s;
                cw_buf[base + w*len + p] = s;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // registers at reset value: one codeword, distance mode, no pair
    task automatic test_reset_defaults();
        cw_buf[0] = 32'hA5A5_5A5A;
        send_load(1);
    endtask

    // symbol extremes and the compare width of the U32, U8 and U16 element types
    task automatic test_symbol_extremes();
        set_config(9'd2, 9'd3, 9'd0, DATA_W'(ET_U32));
        cw_buf[0] = 32'h0000_0000; cw_buf[1] = 32'hFFFF_FFFF;
        cw_buf[2] = 32'h8000_0000; cw_buf[3] = 32'hFFFF_FFFF;
        cw_buf[4] = 32'h0000_0000; cw_buf[5] = 32'h7FFF_FFFF;
        send_load(6);
        // upper bits differ, low byte equal
        set_config(9'd1, 9'd2, 9'd0, DATA_W'(ET_U8));
        cw_buf[0] = 32'hFFFF_FF00; cw_buf[1] = 32'h0000_0000;
        send_load(2);
        set_config(9'd1, 9'd2, 9'd0, DATA_W'(ET_U16));
        cw_buf[0] = 32'hFFFF_0000; cw_buf[1] = 32'h0000_0000;
        send_load(2);
    endtask

    // zero codewords are skipped, all zero gives none found
    task automatic test_linear_weight();
        set_config(9'd3, 9'd3, 9'd1, DATA_W'(ET_U8));
        cw_buf[0] = 32'h0; cw_buf[1] = 32'h0; cw_buf[2] = 32'h0;
        cw_buf[3] = 32'h0000_0100; cw_buf[4] = 32'h0; cw_buf[5] = 32'h8000_0000;
        cw_buf[6] = 32'h0; cw_buf[7] = 32'h0000_0001; cw_buf[8] = 32'h0000_00FF;
        send_load(9);
        set_config(9'd1, 9'd2, 9'd1, DATA_W'(ET_S32));
        cw_buf[0] = 32'h0; cw_buf[1] = 32'h0;
        send_load(2);
    endtask

    // unknown element type counts no position
    task automatic test_unknown_type();
        set_config(9'd2, 9'd2, 9'd0, DATA_W'(ET_UNKNOWN_LO));
        cw_buf[0] = 32'h1; cw_buf[1] = 32'h2; cw_buf[2] = 32'h3; cw_buf[3] = 32'h4;
        send_load(4);
        set_config(9'd1, 9'd1, 9'd1, DATA_W'(ET_UNKNOWN_HI));
        cw_buf[0] = 32'hFFFF_FFFF;
        send_load(1);
    endtask

    // length and count of zero act as one
    task automatic test_zero_sizes();
        set_config(9'd0, 9'd0, 9'd0, DATA_W'(ET_U32));
        cw_buf[0] = 32'h5;
        send_load(1);
        set_config(9'd0, 9'd0, 9'd1, DATA_W'(ET_U32));
        cw_buf[0] = 32'h5;
        send_load(1);
    endtask

    // largest length and count, directly and through saturation
    task automatic test_size_extremes();
        set_config(9'd32, 9'd2, 9'd0, DATA_W'(ET_U32));
        fill_random_load(0, 32, 2);
        send_load(64);
        set_config(9'h1FF, 9'd3, 9'd1, DATA_W'(ET_S32));
        fill_random_load(0, 32, 3);
        send_load(96);
        set_config(9'd1, 9'd256, 9'd0, DATA_W'(ET_U8));
        fill_random_load(0, 1, 256);
        send_load(256);
        set_config(9'd1, 9'h1FF, 9'd1, DATA_W'(ET_U16));
        fill_random_load(0, 1, 256);
        send_load(256);
    endtask

    // long receiver hold while the sender keeps offering loads
    task automatic test_backpressure();
        set_config(9'd2, 9'd3, 9'd0, DATA_W'(ET_U32));
        for (int unsigned n = 0; n < 5; n++) fill_random_load(n * 6, 2, 3);
        rx_hold_cycles = HOLD_CYCLES;
        send_load(30);
        wait_for_results();
    endtask

    // random settings, one to three loads per setting
    task automatic test_random_loads();
        int unsigned      sent;
        int unsigned      r;
        int unsigned      len;
        int unsigned      cnt;
        int unsigned      loads;
        logic [5:0]       len_raw;
        logic [8:0]       cnt_raw;
        logic [DATA_W-1:0] len_d;
        logic [DATA_W-1:0] lin_d;
        logic [DATA_W-1:0] et_d;
        sent = 0;
        while (sent < RANDOM_SYMBOLS) begin
            r = $urandom_range(0, 99);
            if (r < 70)      len_raw = 6'($urandom_range(1, 8));
            else if (r < 85) len_raw = 6'($urandom_range(9, 32));
            else if (r < 92) len_raw = '0;
            else             len_raw = 6'($urandom_range(33, 63));
            len     = clamp_length(len_raw);
            cnt_raw = (len > 8) ? 9'($urandom_range(0, 6)) : 9'($urandom_range(0, 12));
            cnt     = clamp_count(cnt_raw);
            // unused upper data bits carry noise
            len_d       = DATA_W'($urandom_range(0, 511));
            len_d[5:0]  = len_raw;
            lin_d       = DATA_W'($urandom_range(0, 511));
            et_d        = DATA_W'($urandom_range(0, 511));
            if ($urandom_range(0, 4) != 0) et_d[2] = 1'b0;
            set_config(len_d, cnt_raw, lin_d, et_d);
            sender_idle_en   = ($urandom_range(0, 3) != 0);
            receiver_idle_en = sender_idle_en;
            loads = $urandom_range(1, 3);
            for (int unsigned n = 0; n < loads; n++) fill_random_load(n * len * cnt, len, cnt);
            send_load(loads * len * cnt);
            sent += loads * len * cnt;
        end
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_symbol_extremes();
        test_linear_weight();
        test_unknown_type();
        test_zero_sizes();
        test_size_extremes();
        test_backpressure();
        test_random_loads();
        wait_for_results();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
